// ===== rtl/order_table_matcher_assert.svh =====
// assertion macros used by the order table matcher controller
`ifndef ORDER_TABLE_MATCHER_ASSERT_SVH
`define ORDER_TABLE_MATCHER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define OTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define OTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/otm_pkg.sv =====
// shared types and codes for the order table matcher
`timescale 1ns / 1ps
package otm_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_MODIFY = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_VIEW   = 3'd3;
  localparam logic [2:0] OP_MATCH  = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_PAIR      = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic        side;
    logic [30:0] order_id;
    logic [31:0] price;
    logic [30:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] buy_id;
    logic [30:0] sell_id;
    logic [31:0] found_price;
    logic [30:0] found_quantity;
    logic        last;
  } out_item_t;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,      // capture input item, reset scan index
    DP_SCAN_NEXT, // step lookup index
    DP_APPEND,    // write new entry on chosen side
    DP_MODIFY,    // overwrite price and quantity at index
    DP_SHIFT,     // move entry index+1 down to index on chosen side
    DP_SHIFT_BUY, // move buy entry down, index is buy index
    DP_DEC,       // decrement count of chosen side
    DP_DEC_BUY,   // decrement buy count
    DP_SELL_NEXT, // next sell entry, restart buy index
    DP_BUY_NEXT,  // next buy entry
    DP_OUT        // load output register
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [1:0]  status;
    logic        sel_id;    // buy_id from input id
    logic        sel_data;  // price/qty from entry
    logic        sel_pair;  // pair result
    logic        last;
  } dp_cmd_t;

  typedef struct packed {
    logic       full;      // chosen side full
    logic       idx_end;   // index reached chosen count
    logic       id_hit;    // entry at index has input id
    logic       shift_end; // index+1 reached count
    logic       sell_end;  // sell index reached sell count
    logic       buy_end;   // buy index reached buy count
    logic       pair_hit;  // buy entry matches sell entry
    logic       buy_shift_end;
    logic [2:0] op;
  } dp_stat_t;

endpackage

// ===== rtl/order_table_matcher.sv =====
// top level of the order table matcher
`timescale 1ns / 1ps
// Buy and sell order tables of TABLE_DEPTH entries each, with add, modify,
// delete, view and match-all operations. One item is taken at a time; in_stall
// stays high until its last result is in the output register. Modify, delete and
// view scan the table one entry a cycle, and delete then shifts the tail down
// one entry a cycle. Match walks sell entries against buy entries one compare a
// cycle, but a matched pair waits while the output register holds a result. A
// held result in the output register stalls the next result until it is
// drained. No clearing pass after reset.
module order_table_matcher import otm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  otm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  // tables and result register
  otm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_data
  );

endmodule

// ===== rtl/otm_datapath.sv =====
// order tables, scan indexes and output register
`timescale 1ns / 1ps
module otm_datapath import otm_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [30:0] ids_r   [2][TABLE_DEPTH];
  logic [31:0] prices_r[2][TABLE_DEPTH];
  logic [30:0] qtys_r  [2][TABLE_DEPTH];
  logic [CW-1:0] cnt_r [2];
  in_item_t  item_r;
  logic [CW-1:0] idx_r;  // lookup index, or sell index during match
  logic [CW-1:0] bidx_r; // buy index during match
  out_item_t out_r;

  logic side;
  logic [IW-1:0] ia, ia1, ba, ba1;
  assign side = item_r.side;
  assign ia  = idx_r[IW-1:0];
  assign ia1 = IW'(idx_r + 1'b1);
  assign ba  = bidx_r[IW-1:0];
  assign ba1 = IW'(bidx_r + 1'b1);

  // status toward the controller
  always_comb begin
    stat.full          = (cnt_r[side] >= DEPTH_C);
    stat.idx_end       = (idx_r >= cnt_r[side]);
    stat.id_hit        = (ids_r[side][ia] == item_r.order_id);
    stat.shift_end     = ((idx_r + 1'b1) >= cnt_r[side]);
    stat.sell_end      = (idx_r >= cnt_r[SIDE_SELL]);
    stat.buy_end       = (bidx_r >= cnt_r[SIDE_BUY]);
    stat.pair_hit      = (prices_r[SIDE_BUY][ba] == prices_r[SIDE_SELL][ia]) &&
                         (qtys_r[SIDE_BUY][ba] == qtys_r[SIDE_SELL][ia]);
    stat.buy_shift_end = ((bidx_r + 1'b1) >= cnt_r[SIDE_BUY]);
    stat.op            = item_r.op;
  end

  // counts and indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      idx_r    <= '0;
      bidx_r   <= '0;
    end else begin
      unique case (cmd.op)
        DP_LOAD:      begin idx_r <= '0; bidx_r <= '0; end
        DP_SCAN_NEXT: idx_r <= idx_r + 1'b1;
        DP_APPEND:    cnt_r[side] <= cnt_r[side] + 1'b1;
        DP_SHIFT:     idx_r <= idx_r + 1'b1;
        DP_SHIFT_BUY: bidx_r <= bidx_r + 1'b1;
        DP_DEC:       cnt_r[side] <= cnt_r[side] - 1'b1;
        DP_DEC_BUY:   cnt_r[SIDE_BUY] <= cnt_r[SIDE_BUY] - 1'b1;
        DP_SELL_NEXT: begin idx_r <= idx_r + 1'b1; bidx_r <= '0; end
        DP_BUY_NEXT:  bidx_r <= bidx_r + 1'b1;
        default: ;
      endcase
    end
  end

  // table storage and captured item
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) item_r <= in_data;
    unique case (cmd.op)
      DP_APPEND: begin
        ids_r[side][cnt_r[side][IW-1:0]]    <= item_r.order_id;
        prices_r[side][cnt_r[side][IW-1:0]] <= item_r.price;
        qtys_r[side][cnt_r[side][IW-1:0]]   <= item_r.quantity;
      end
      DP_MODIFY: begin
        prices_r[side][ia] <= item_r.price;
        qtys_r[side][ia]   <= item_r.quantity;
      end
      DP_SHIFT: begin
        ids_r[side][ia]    <= ids_r[side][ia1];
        prices_r[side][ia] <= prices_r[side][ia1];
        qtys_r[side][ia]   <= qtys_r[side][ia1];
      end
      DP_SHIFT_BUY: begin
        ids_r[SIDE_BUY][ba]    <= ids_r[SIDE_BUY][ba1];
        prices_r[SIDE_BUY][ba] <= prices_r[SIDE_BUY][ba1];
        qtys_r[SIDE_BUY][ba]   <= qtys_r[SIDE_BUY][ba1];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_r.status         <= cmd.status;
      out_r.last           <= cmd.last;
      out_r.buy_id         <= cmd.sel_pair ? ids_r[SIDE_BUY][ba] :
                              (cmd.sel_id ? item_r.order_id : '0);
      out_r.sell_id        <= cmd.sel_pair ? ids_r[SIDE_SELL][ia] : '0;
      out_r.found_price    <= cmd.sel_pair ? prices_r[SIDE_SELL][ia] :
                              (cmd.sel_data ? prices_r[side][ia] : '0);
      out_r.found_quantity <= cmd.sel_pair ? qtys_r[SIDE_SELL][ia] :
                              (cmd.sel_data ? qtys_r[side][ia] : '0);
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/otm_ctrl.sv =====
// sequencing state machine for the order table matcher
`timescale 1ns / 1ps
module otm_ctrl import otm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  `include "order_table_matcher_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_SHIFT = 10'b0000001000,
    S_MSELL = 10'b0000010000,
    S_MBUY  = 10'b0000100000,
    S_MSHFT = 10'b0001000000,
    S_WAIT  = 10'b0010000000,
    S_MWAIT = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   free;

  // output register may be loaded when empty or being drained
  assign free      = !ovalid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '{op: DP_NOP, status: ST_DONE, sel_id: 1'b0, sel_data: 1'b0,
                   sel_pair: 1'b0, last: 1'b1};
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = DP_LOAD;
        state_nxt = S_DISP;
      end
      S_DISP: if (stat.op == OP_ADD || stat.op == OP_MODIFY || stat.op == OP_DELETE ||
                  stat.op == OP_VIEW) begin
        if (stat.op == OP_ADD) begin
          if (free) begin
            cmd.op     = stat.full ? DP_OUT : DP_APPEND;
            state_nxt  = stat.full ? S_IDLE : S_WAIT;
            cmd.status = ST_FULL;
            cmd.sel_id = 1'b1;
            ovalid_nxt = stat.full ? 1'b1 : ovalid_nxt;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end else if (stat.op == OP_MATCH) begin
        state_nxt = S_MSELL;
      end else if (free) begin
        cmd.op     = DP_OUT;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.sel_id = 1'b1;
        if (stat.idx_end) begin
          if (free) begin
            cmd.op     = DP_OUT;
            cmd.status = ST_NOT_FOUND;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (stat.id_hit) begin
          if (stat.op == OP_MODIFY) begin
            cmd.op    = DP_MODIFY;
            state_nxt = S_WAIT;
          end else if (stat.op == OP_DELETE) begin
            state_nxt = S_SHIFT;
          end else if (free) begin
            cmd.op       = DP_OUT;
            cmd.sel_data = 1'b1;
            ovalid_nxt   = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.op = DP_SCAN_NEXT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          cmd.op    = DP_DEC;
          state_nxt = S_FIN;
        end else begin
          cmd.op = DP_SHIFT;
        end
      end
      S_FIN: if (free) begin
        cmd.op     = DP_OUT;
        cmd.sel_id = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_WAIT: if (free) begin
        // add or modify result; modify shows the entry after the write
        cmd.op       = DP_OUT;
        cmd.sel_id   = 1'b1;
        cmd.sel_data = (stat.op == OP_MODIFY);
        ovalid_nxt   = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_MSELL: begin
        if (stat.sell_end) begin
          if (free) begin
            cmd.op     = DP_OUT;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_MBUY;
        end
      end
      S_MBUY: begin
        if (stat.buy_end) begin
          cmd.op    = DP_SELL_NEXT;
          state_nxt = S_MSELL;
        end else if (stat.pair_hit) begin
          if (free) begin
            cmd.op       = DP_OUT;
            cmd.status   = ST_PAIR;
            cmd.sel_pair = 1'b1;
            cmd.last     = 1'b0;
            ovalid_nxt   = 1'b1;
            state_nxt    = S_MSHFT;
          end
        end else begin
          cmd.op = DP_BUY_NEXT;
        end
      end
      S_MSHFT: begin
        if (stat.buy_shift_end) begin
          cmd.op    = DP_DEC_BUY;
          state_nxt = S_MWAIT;
        end else begin
          cmd.op = DP_SHIFT_BUY;
        end
      end
      S_MWAIT: begin
        cmd.op    = DP_SELL_NEXT;
        state_nxt = S_MSELL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  `OTM_ASSERT_IMP(a_load_idle, cmd.op == DP_OUT, free, "output overwritten while held")
  `OTM_ASSERT_NXT(a_take_busy, in_valid && !in_stall, state_r == S_DISP,
                  "accepted item not dispatched")
  `OTM_ASSERT_NXT(a_out_hold, ovalid_r && out_stall, ovalid_r, "held result dropped")

endmodule
